@@ sv/assert_macros.svh @@
// assertion macros for the port-level checker of the interleaver
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/bpsi_pkg.sv @@
// shared types, constants and a helper function of the bit plane step interleaver
// no dependencies; used by the lane, merge and top-level modules
package bpsi_pkg;

    localparam int NUM_AXES   = 4;
    localparam int COUNT_BITS = 8;
    localparam int IN_AXES    = 4;
    localparam int OUT_AXES   = 4;
    localparam int LANES      = (NUM_AXES < IN_AXES) ? NUM_AXES : IN_AXES;
    localparam int DEPTH      = 8;
    localparam int PLANE_W    = 3;
    localparam int IDX_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef logic [OUT_AXES-1:0] t_mask;
    typedef logic [BYTE_W-1:0]   t_count;
    typedef logic [DEPTH-1:0]    t_column;
    typedef logic [PLANE_W-1:0]  t_plane_sel;
    typedef logic [IDX_W-1:0]    t_index;

    // start index per depth-1: 2^depth - 2
    localparam t_index START_INDEX [DEPTH] = '{
        8'd0, 8'd2, 8'd6, 8'd14, 8'd30, 8'd62, 8'd126, 8'd254
    };

    // lowest set bit; all-zero input gives the last plane
    function automatic t_plane_sel trailing_zeros(input t_index v);
        t_plane_sel n;
        n = t_plane_sel'(DEPTH - 1);
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (v[i]) begin
                n = t_plane_sel'(i);
            end
        end
        return n;
    endfunction

endpackage

@@ sv/bpsi_lane.sv @@
// one axis lane: masks the step count and lays out its bits highest plane first
// depends on bpsi_pkg
module bpsi_lane (
    input  bpsi_pkg::t_count     i_count,
    input  bpsi_pkg::t_plane_sel i_top,
    output bpsi_pkg::t_count     o_count,
    output bpsi_pkg::t_column    o_column
);

    always_comb begin
        for (int b = 0; b < bpsi_pkg::BYTE_W; b++) begin
            o_count[b] = (b < bpsi_pkg::COUNT_BITS) ? i_count[b] : 1'b0;
        end
    end

    // entry j carries the bit of weight 2^(top-j); entries past top are empty
    always_comb begin
        for (int j = 0; j < bpsi_pkg::DEPTH; j++) begin
            if (bpsi_pkg::t_plane_sel'(j) <= i_top) begin
                o_column[j] = o_count[i_top - bpsi_pkg::t_plane_sel'(j)];
            end else begin
                o_column[j] = 1'b0;
            end
        end
    end

endmodule

@@ sv/bpsi_merge.sv @@
// merging stage: combines the lane counts into the highest plane of the move
// depends on bpsi_pkg
module bpsi_merge (
    input  bpsi_pkg::t_count     i_counts [bpsi_pkg::LANES],
    output bpsi_pkg::t_plane_sel o_top
);

    bpsi_pkg::t_count w_any;

    always_comb begin
        w_any = '0;
        for (int a = 0; a < bpsi_pkg::LANES; a++) begin
            w_any = w_any | i_counts[a];
        end
    end

    // highest set bit, at least plane zero
    always_comb begin
        o_top = '0;
        for (int k = 0; k < bpsi_pkg::DEPTH; k++) begin
            if (w_any[k]) begin
                o_top = bpsi_pkg::t_plane_sel'(k);
            end
        end
    end

endmodule

@@ sv/bit_plane_step_interleaver.sv @@
// bit plane step interleaver: the result request is registered from the input request,
// one request per cycle while the output is not stalled; the index decrement and
// trailing-zero plane select are combinational, and one output register parts the two channels
// synchronous active-low reset clears the active and pending move state and the
// output valid; pending planes are loaded before use and carry no reset
// depends on bpsi_pkg, bpsi_lane, bpsi_merge
module bit_plane_step_interleaver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // step_counts[31:0], direction_mask[35:32], zero pad [39:36]
    input  logic [bpsi_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // func: 0 tick, 1 load
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // step_mask[3:0], active_direction[7:4], stepping[8], load_accepted[9], pad
    output logic [bpsi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // last_tick
    output logic                           m_axis_tlast
);

    // active and pending move
    bpsi_pkg::t_mask  r_act_planes [bpsi_pkg::DEPTH];
    bpsi_pkg::t_mask  r_pend_planes [bpsi_pkg::DEPTH];
    bpsi_pkg::t_index r_act_index, r_pend_index;
    bpsi_pkg::t_mask  r_act_dir, r_pend_dir;
    logic             r_act_valid, r_pend_valid;

    // output register
    logic             r_out_valid;
    bpsi_pkg::t_mask  r_out_step, r_out_dir;
    logic             r_out_stepping, r_out_last, r_out_acc;

    bpsi_pkg::t_mask  n_out_step, n_out_dir;
    logic             n_out_stepping, n_out_last, n_out_acc;

    logic             w_accept;
    logic             w_is_load;

    // lanes and merge
    bpsi_pkg::t_count     w_in_counts [bpsi_pkg::LANES];
    bpsi_pkg::t_count     w_counts [bpsi_pkg::LANES];
    bpsi_pkg::t_column    w_columns [bpsi_pkg::LANES];
    bpsi_pkg::t_plane_sel w_top;
    bpsi_pkg::t_mask      w_new_planes [bpsi_pkg::DEPTH];

    // move seen by a tick: the active one, or the pending one promoted at once
    logic                 w_eff_valid;
    bpsi_pkg::t_index     w_eff_index;
    bpsi_pkg::t_mask      w_eff_dir;
    bpsi_pkg::t_plane_sel w_sel;
    bpsi_pkg::t_mask      w_eff_plane;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_load     = (s_axis_tuser == bpsi_pkg::FUNC_LOAD);

    // one lane per axis that the input carries
    for (genvar a = 0; a < bpsi_pkg::LANES; a++) begin : g_lane
        assign w_in_counts[a] = s_axis_tdata[a*bpsi_pkg::BYTE_W +: bpsi_pkg::BYTE_W];

        bpsi_lane u_lane (
            .i_count  (w_in_counts[a]),
            .i_top    (w_top),
            .o_count  (w_counts[a]),
            .o_column (w_columns[a])
        );
    end

    bpsi_merge u_merge (
        .i_counts (w_counts),
        .o_top    (w_top)
    );

    // transpose lane columns into plane masks
    always_comb begin
        for (int j = 0; j < bpsi_pkg::DEPTH; j++) begin
            w_new_planes[j] = '0;
            for (int a = 0; a < bpsi_pkg::LANES; a++) begin
                w_new_planes[j][a] = w_columns[a][j];
            end
        end
    end

    // tick path: pick the move, then the plane by trailing zeros of index+1
    assign w_eff_valid = r_act_valid || r_pend_valid;
    assign w_eff_index = r_act_valid ? r_act_index : r_pend_index;
    assign w_eff_dir   = r_act_valid ? r_act_dir : r_pend_dir;
    assign w_sel       = bpsi_pkg::trailing_zeros(w_eff_index + bpsi_pkg::t_index'(1));
    assign w_eff_plane = r_act_valid ? r_act_planes[w_sel] : r_pend_planes[w_sel];

    always_comb begin
        n_out_step     = '0;
        n_out_dir      = '0;
        n_out_stepping = 1'b0;
        n_out_last     = 1'b0;
        n_out_acc      = 1'b0;
        if (w_is_load) begin
            n_out_dir = r_act_valid ? r_act_dir : '0;
            n_out_acc = !r_pend_valid;
        end else if (w_eff_valid) begin
            n_out_step     = w_eff_plane;
            n_out_dir      = w_eff_dir;
            n_out_stepping = 1'b1;
            n_out_last     = (w_eff_index == '0);
        end
    end

    // move state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_act_index  <= '0;
            r_pend_index <= '0;
            r_act_dir    <= '0;
            r_pend_dir   <= '0;
            for (int j = 0; j < bpsi_pkg::DEPTH; j++) begin
                r_act_planes[j] <= '0;
            end
        end else if (w_accept) begin
            if (w_is_load) begin
                // refused while the pending slot is taken
                if (!r_pend_valid) begin
                    r_pend_planes <= w_new_planes;
                    r_pend_index  <= bpsi_pkg::START_INDEX[w_top];
                    r_pend_dir    <= s_axis_tdata[32 +: bpsi_pkg::OUT_AXES];
                    r_pend_valid  <= 1'b1;
                end
            end else if (r_act_valid) begin
                if (r_act_index == '0) begin
                    // move ends: promote the pending one or go idle
                    r_act_valid <= r_pend_valid;
                    if (r_pend_valid) begin
                        r_act_planes <= r_pend_planes;
                        r_act_index  <= r_pend_index;
                        r_act_dir    <= r_pend_dir;
                        r_pend_valid <= 1'b0;
                    end
                end else begin
                    r_act_index <= r_act_index - bpsi_pkg::t_index'(1);
                end
            end else if (r_pend_valid) begin
                // idle tick promotes the pending move and steps it
                r_pend_valid <= 1'b0;
                r_act_planes <= r_pend_planes;
                r_act_dir    <= r_pend_dir;
                if (r_pend_index == '0) begin
                    r_act_valid <= 1'b0;
                end else begin
                    r_act_valid <= 1'b1;
                    r_act_index <= r_pend_index - bpsi_pkg::t_index'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_step     <= n_out_step;
            r_out_dir      <= n_out_dir;
            r_out_stepping <= n_out_stepping;
            r_out_last     <= n_out_last;
            r_out_acc      <= n_out_acc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {6'b0, r_out_acc, r_out_stepping, r_out_dir, r_out_step};

endmodule

@@ sv/bpsi_checker.sv @@
// port-level checks of the bit plane step interleaver, bound to the top level
// depends on assert_macros.svh and bpsi_pkg
`include "assert_macros.svh"

module bpsi_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bpsi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    logic                            w_stall;
    logic                            w_stepping;
    logic                            w_acc;
    logic                            w_load_res;
    logic [3:0]                      w_step_mask;
    logic [bpsi_pkg::OUT_DATA_W:0]   w_out_bits;

    assign w_stall     = m_axis_tvalid && !m_axis_tready;
    assign w_stepping  = m_axis_tdata[8];
    assign w_acc       = m_axis_tdata[9];
    assign w_load_res  = m_axis_tvalid && w_acc;
    assign w_step_mask = m_axis_tdata[3:0];
    assign w_out_bits  = {m_axis_tlast, m_axis_tdata};

    // stalled result holds
    `CHK_NEXT(a_stall_hold, i_clk, i_rst_n, w_stall, m_axis_tvalid && $stable(w_out_bits))

    // last flag only on a tick from a move
    `CHK_IMPLY(a_last_steps, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, w_stepping)

    // accepted load carries no steps
    `CHK_IMPLY(a_load_quiet, i_clk, i_rst_n, w_load_res, !w_stepping && !m_axis_tlast && !(|w_step_mask))

    // steps only from an active move
    `CHK_IMPLY(a_step_active, i_clk, i_rst_n, m_axis_tvalid && (|w_step_mask), w_stepping)

endmodule

bind bit_plane_step_interleaver bpsi_checker u_bpsi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/bpsi_step_checker.sv @@
`timescale 1ns / 1ps
// checker for the bit plane step interleaver: watches both stream channels,
// predicts every result from the accepted requests and compares field by field
// depends on bpsi_pkg for widths, types and request codes
module bpsi_step_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // step_counts[31:0], direction_mask[35:32], zero pad [39:36]
    input  logic [bpsi_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // func: 0 tick, 1 load
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // step_mask[3:0], active_direction[7:4], stepping[8], load_accepted[9], pad
    input  logic [bpsi_pkg::OUT_DATA_W-1:0] i_m_tdata,
    // last_tick
    input  logic                            i_m_tlast,
    output int                              o_fail_count,
    output int                              o_results_due
);
    import bpsi_pkg::*;

    typedef struct packed {
        t_mask step_mask;
        t_mask direction;
        logic  stepping;
        logic  last_tick;
        logic  load_accepted;
    } step_result_t;

    step_result_t expected_steps [$];
    int           mismatches = 0;

    // running move and the one-deep queued move, planes highest weight first
    t_mask  run_planes    [DEPTH];
    t_mask  queued_planes [DEPTH];
    t_index run_index;
    t_index queued_index;
    t_mask  run_dir;
    t_mask  queued_dir;
    logic   run_valid;
    logic   queued_valid;

    function automatic void clear_moves();
        for (int j = 0; j < DEPTH; j++) begin
            run_planes[j]    = '0;
            queued_planes[j] = '0;
        end
        run_index    = '0;
        queued_index = '0;
        run_dir      = '0;
        queued_dir   = '0;
        run_valid    = 1'b0;
        queued_valid = 1'b0;
    endfunction

    function automatic void promote_queued_move();
        if (queued_valid) begin
            run_planes   = queued_planes;
            run_index    = queued_index;
            run_dir      = queued_dir;
            run_valid    = 1'b1;
            queued_valid = 1'b0;
        end else begin
            run_valid = 1'b0;
        end
    endfunction

    // plane picked by the lowest set bit of index + 1
    function automatic int plane_for_index(t_index idx);
        logic [IDX_W:0] v;
        int             sel;
        v   = {1'b0, idx} + 1'b1;
        sel = DEPTH - 1;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (v[k]) begin
                sel = k;
            end
        end
        return sel;
    endfunction

    function automatic step_result_t predict_step_result(logic func, logic [31:0] counts,
                                                         t_mask dir);
        step_result_t r;
        t_mask        planes [DEPTH];
        int           depth;
        r = '0;
        if (func == FUNC_LOAD) begin
            if (!queued_valid) begin
                depth = 1;
                for (int k = 0; k < COUNT_BITS; k++) begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        planes[k][a] = counts[8*a + k];
                    end
                    if (planes[k] != '0) begin
                        depth = k + 1;
                    end
                end
                for (int j = 0; j < DEPTH; j++) begin
                    queued_planes[j] = (j < depth) ? planes[depth - 1 - j] : '0;
                end
                // 2^depth - 2 ticks after the first one
                queued_index    = t_index'((1 << depth) - 2);
                queued_dir      = dir;
                queued_valid    = 1'b1;
                r.load_accepted = 1'b1;
            end
            r.direction = run_valid ? run_dir : '0;
        end else begin
            if (!run_valid) begin
                promote_queued_move();
            end
            if (run_valid) begin
                r.step_mask = run_planes[plane_for_index(run_index)];
                r.direction = run_dir;
                r.stepping  = 1'b1;
                if (run_index == '0) begin
                    r.last_tick = 1'b1;
                    promote_queued_move();
                end else begin
                    run_index = run_index - 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        step_result_t got;
        step_result_t want;
        if (!i_rst_n) begin
            clear_moves();
            expected_steps.delete();
        end else begin
            // results first: a request taken at this edge cannot be answered yet
            if (i_m_tvalid && i_m_tready) begin
                got.step_mask     = i_m_tdata[3:0];
                got.direction     = i_m_tdata[7:4];
                got.stepping      = i_m_tdata[8];
                got.load_accepted = i_m_tdata[9];
                got.last_tick     = i_m_tlast;
                if (expected_steps.size() == 0) begin
                    $error("result with no request waiting: tdata %0h, tlast %0b",
                           i_m_tdata, i_m_tlast);
                    mismatches++;
                end else begin
                    want = expected_steps.pop_front();
                    check_field("step_mask", want.step_mask, got.step_mask);
                    check_field("active_direction", want.direction, got.direction);
                    check_field("stepping", want.stepping, got.stepping);
                    check_field("last_tick", want.last_tick, got.last_tick);
                    check_field("load_accepted", want.load_accepted, got.load_accepted);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_steps.push_back(predict_step_result(i_s_tuser, i_s_tdata[31:0],
                                                             i_s_tdata[35:32]));
            end
        end
        o_fail_count  <= mismatches;
        o_results_due <= expected_steps.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// top of the bit plane step interleaver bench: clock, reset, request stimulus,
// output backpressure and the verdict; depends on bpsi_pkg, the block and bpsi_step_checker
module tb_top;
    import bpsi_pkg::*;

    localparam int RANDOM_REQUESTS = 830;
    localparam int QUIET_LIMIT     = 2000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES     = 150;    // long receiver stall to fill the block
    localparam int DRAIN_CYCLES    = 10;     // the result is registered, keep a margin

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // step_counts[31:0], direction_mask[35:32], zero pad [39:36]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // func: 0 tick, 1 load
    logic                  s_axis_tuser  = FUNC_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // step_mask[3:0], active_direction[7:4], stepping[8], load_accepted[9], pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // last_tick
    logic                  m_axis_tlast;

    int fail_count;
    int results_due;

    // idle phase: 0 sender light / receiver heavy, 1 the reverse, 2 no idling
    int phase = 0;
    int send_idle_pct;
    int recv_idle_pct;
    assign send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 66 : 0;
    assign recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 38 : 0;

    always #4 i_clk = ~i_clk;

    bit_plane_step_interleaver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bpsi_step_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tlast     (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    // drive one request at the falling edge, after a random number of idle cycles,
    // and hold it until the block takes it at a rising edge
    task automatic send_request(logic func, logic [31:0] counts, logic [3:0] dir);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {4'b0000, dir, counts};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // ticks carry a payload the block ignores; keep it random anyway
    task automatic send_tick();
        send_request(FUNC_TICK, $urandom, 4'($urandom_range(0, 15)));
    endtask

    // mostly shallow moves so they drain quickly, now and then a full-depth one
    function automatic logic [31:0] random_counts();
        logic [7:0]  depth_mask;
        logic [31:0] c;
        if ($urandom_range(0, 24) == 0) begin
            depth_mask = 8'hff;
        end else begin
            depth_mask = 8'((1 << $urandom_range(1, 4)) - 1);
        end
        c = $urandom & {4{depth_mask}};
        // all-zero move: one tick with no steps
        if ($urandom_range(0, 9) == 0) begin
            c = '0;
        end
        return c;
    endfunction

    // receiver: random stalls per phase, plus one long hold when the no-idle
    // phase starts, so the block fills up and stalls its input side
    int   hold_left = 0;
    logic hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (phase == 2 && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog: any handshake on either channel restarts the count
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_tick();                                    // idle tick, all zero
        send_request(FUNC_LOAD, 32'h0000_0000, 4'h0);   // all counts zero
        send_tick();                                    // promoted, one empty tick
        send_tick();                                    // idle again
        send_request(FUNC_LOAD, 32'h0101_0101, 4'hf);   // one plane, every axis
        send_request(FUNC_LOAD, 32'h0203_0405, 4'h5);   // queued slot full, refused
        send_tick();                                    // promote and finish at once
        send_tick();                                    // nothing left to promote
        send_request(FUNC_LOAD, 32'h0000_0003, 4'ha);   // two planes on axis 0
        send_tick();
        send_request(FUNC_LOAD, 32'h0000_0100, 4'h3);   // queued behind a running move
        send_tick();
        send_tick();                                    // last tick promotes the queued move
        send_tick();
        send_request(FUNC_LOAD, 32'hffff_ffff, 4'hf);   // deepest move, all axes
        send_request(FUNC_LOAD, 32'h8080_8080, 4'h0);   // refused
        send_tick();
        send_request(FUNC_LOAD, 32'h8000_0001, 4'h9);   // queued behind the deep move
        send_tick();

        // random part, split over the three idle phases
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            phase = (n * 3) / RANDOM_REQUESTS;
            if ($urandom_range(0, 99) < 20) begin
                send_request(FUNC_LOAD, random_counts(), 4'($urandom_range(0, 15)));
            end else begin
                send_tick();
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (results_due != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
